// ===== rtl/irf_pkg.sv =====
// shared types, constants and a helper function of the integer radix formatter
package irf_pkg;

    localparam int VALUE_BITS        = 32;
    localparam int DIGIT_STORE_DEPTH = 36;
    localparam int MAX_FIELD         = 64;

    localparam int RADIX_W  = 6;
    localparam int FIELD_W  = 7;
    localparam int PREC_W   = 6;
    localparam int DIGIT_W  = 6;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 7;

    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 36;
    localparam int PREC_MAX  = MAX_FIELD - 3;

    // long division runs eight quotient bits per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam int DADDR_W = $clog2(DIGIT_STORE_DEPTH);
    localparam int DCNT_W  = $clog2(DIGIT_STORE_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef enum logic [1:0]
    {
        PAD_LEAD,
        PAD_FILL,
        PAD_TRAIL
    } pad_mode_t;

    typedef enum logic [3:0]
    {
        B_IDLE,
        B_DIV,
        B_PLAN,
        B_LEAD,
        B_SIGN,
        B_PREFIX,
        B_FILL,
        B_PREC,
        B_DIGITS,
        B_TRAIL,
        B_ERROR
    } back_state_t;

    typedef struct packed
    {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]    radix;
        logic [FIELD_W-1:0]    min_width;
        logic [PREC_W-1:0]     min_digits;
        logic                  left_align;
        logic                  zero_pad;
        logic                  show_plus;
        logic                  space_sign;
        logic                  alt_prefix;
        logic                  lower_case;
        logic                  is_signed;
    } in_item_t;

    typedef struct packed
    {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
        logic              bad_radix;
    } out_item_t;

    // classified work item handed from front to back
    typedef struct packed
    {
        logic                  bad;
        logic [VALUE_BITS-1:0] mag;
        logic [RADIX_W-1:0]    radix;
        logic [FIELD_W-1:0]    width;
        logic [PREC_W-1:0]     prec;
        logic                  has_sign;
        logic [CHAR_W-1:0]     sign_char;
        logic [1:0]            prefix_len;
        logic                  lower;
        pad_mode_t             pad_mode;
    } job_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                      input logic lower);
        logic [CHAR_W-1:0] base;
        base = lower ? CHAR_LO_A : CHAR_UP_A;
        if (d < DIGIT_W'(10))
            digit_char = CHAR_ZERO + CHAR_W'(d);
        else
            digit_char = base + CHAR_W'(d - DIGIT_W'(10));
    endfunction

endpackage

// ===== rtl/irf_ram.sv =====
// generic single write port ram with registered read
module irf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/irf_front.sv =====
// front end: input handshake and classification of each number into a job
module irf_front (
    input  irf_pkg::in_item_t in_item,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              q_full,
    output logic              q_push,
    output irf_pkg::job_t     q_job
);
    import irf_pkg::*;

    logic zp;
    logic neg;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        zp  = in_item.zero_pad && !in_item.left_align;
        neg = in_item.is_signed && in_item.value[VALUE_BITS-1];

        q_job.bad = (in_item.radix < RADIX_W'(RADIX_MIN))
                 || (in_item.radix > RADIX_W'(RADIX_MAX));
        q_job.mag = neg ? (~in_item.value + VALUE_BITS'(1)) : in_item.value;
        q_job.radix = in_item.radix;
        q_job.width = (in_item.min_width > FIELD_W'(MAX_FIELD))
                    ? FIELD_W'(MAX_FIELD) : in_item.min_width;
        q_job.prec  = (in_item.min_digits > PREC_W'(PREC_MAX))
                    ? PREC_W'(PREC_MAX) : in_item.min_digits;

        q_job.has_sign  = 1'b1;
        q_job.sign_char = CHAR_NONE;
        if (neg)
            q_job.sign_char = CHAR_MINUS;
        else if (in_item.show_plus)
            q_job.sign_char = CHAR_PLUS;
        else if (in_item.space_sign)
            q_job.sign_char = CHAR_SPACE;
        else
            q_job.has_sign = 1'b0;

        q_job.prefix_len = 2'd0;
        if (in_item.alt_prefix && in_item.radix == RADIX_W'(16))
            q_job.prefix_len = 2'd2;
        else if (in_item.alt_prefix && in_item.radix == RADIX_W'(8))
            q_job.prefix_len = 2'd1;

        q_job.lower = in_item.lower_case;

        if (in_item.left_align)
            q_job.pad_mode = PAD_TRAIL;
        else if (zp)
            q_job.pad_mode = PAD_FILL;
        else
            q_job.pad_mode = PAD_LEAD;
    end

endmodule

// ===== rtl/irf_queue.sv =====
// short register queue of jobs between front and back
module irf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  irf_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output irf_pkg::job_t head_job
);
    import irf_pkg::*;

    job_t               slot_reg [QUEUE_DEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QADDR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QADDR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QADDR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QADDR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/irf_back.sv =====
// back end: digit extraction by iterative division and character sequencing
module irf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  irf_pkg::job_t      q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output irf_pkg::out_item_t out_item
);
    import irf_pkg::*;

    back_state_t         state_reg, state_next;
    job_t                job_reg, job_next;
    logic [DIV_W-1:0]    dv_reg, dv_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DCNT_W-1:0]   dcount_reg, dcount_next;
    logic [DCNT_W-1:0]   dleft_reg, dleft_next;
    logic [DADDR_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    pad_reg, pad_next;
    logic [CNT_W-1:0]    precz_reg, precz_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic [1:0]          pfx_reg, pfx_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    // division datapath
    logic [DIGIT_W-1:0]  r_div;
    logic [DIGIT_W:0]    t_div;
    logic [DIV_BITS-1:0] top_bits;
    logic [DIV_BITS-1:0] q_bits;
    logic [DIV_W-1:0]    dv_shift;
    logic                last_step;

    // plan arithmetic
    logic [CNT_W-1:0]    eff_prec;
    logic [CNT_W-1:0]    fixed_len;

    // digit store ports
    logic                ram_we;
    logic                ram_re;
    logic [DADDR_W-1:0]  ram_raddr;
    logic [DIGIT_W-1:0]  ram_rdata;

    logic                out_free;
    logic                emit;
    logic [CHAR_W-1:0]   emit_char;

    irf_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_STORE_DEPTH)
    ) u_digit_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dcount_reg[DADDR_W-1:0]),
        .wdata (r_div),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));

    // eight restoring division steps on the top byte of the dividend
    always_comb
    begin
        r_div    = rem_reg;
        t_div    = '0;
        q_bits   = '0;
        top_bits = dv_reg[DIV_W-1 -: DIV_BITS];
        for (int i = DIV_BITS - 1; i >= 0; i--)
        begin
            t_div = {r_div, top_bits[i]};
            if (t_div >= {1'b0, job_reg.radix})
            begin
                q_bits[i] = 1'b1;
                r_div     = DIGIT_W'(t_div - {1'b0, job_reg.radix});
            end
            else
            begin
                r_div = t_div[DIGIT_W-1:0];
            end
        end
        dv_shift = (dv_reg << DIV_BITS) | DIV_W'(q_bits);
    end

    always_comb
    begin
        eff_prec  = (CNT_W'(dcount_reg) > CNT_W'(job_reg.prec)) ? CNT_W'(dcount_reg)
                  : CNT_W'(job_reg.prec);
        fixed_len = CNT_W'(job_reg.has_sign) + CNT_W'(job_reg.prefix_len) + eff_prec;
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        dv_next        = dv_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        dcount_next    = dcount_reg;
        dleft_next     = dleft_reg;
        rd_idx_next    = rd_idx_reg;
        pad_next       = pad_reg;
        precz_next     = precz_reg;
        remain_next    = remain_reg;
        pfx_next       = pfx_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg;
        emit           = 1'b0;
        emit_char      = CHAR_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    job_next    = q_head;
                    dv_next     = DIV_W'(q_head.mag);
                    rem_next    = '0;
                    step_next   = '0;
                    dcount_next = '0;
                    pfx_next    = q_head.prefix_len;
                    state_next  = q_head.bad ? B_ERROR : B_DIV;
                end
            end

            B_DIV:
            begin
                dv_next = dv_shift;
                if (last_step)
                begin
                    ram_we      = 1'b1;
                    dcount_next = dcount_reg + DCNT_W'(1);
                    rem_next    = '0;
                    step_next   = '0;
                    if (dv_shift == '0
                        || dcount_reg == DCNT_W'(DIGIT_STORE_DEPTH - 1))
                        state_next = B_PLAN;
                end
                else
                begin
                    rem_next  = r_div;
                    step_next = step_reg + STEP_W'(1);
                end
            end

            B_PLAN:
            begin
                pad_next    = (CNT_W'(job_reg.width) > fixed_len)
                            ? CNT_W'(job_reg.width) - fixed_len : '0;
                remain_next = (CNT_W'(job_reg.width) > fixed_len)
                            ? CNT_W'(job_reg.width) : fixed_len;
                precz_next  = eff_prec - CNT_W'(dcount_reg);
                dleft_next  = dcount_reg;
                // prefetch the most significant digit
                ram_re      = 1'b1;
                ram_raddr   = DADDR_W'(dcount_reg - DCNT_W'(1));
                rd_idx_next = ram_raddr;
                state_next  = B_LEAD;
            end

            B_LEAD:
            begin
                if (job_reg.pad_mode == PAD_LEAD && pad_reg != '0)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_char = CHAR_SPACE;
                        pad_next  = pad_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = B_SIGN;
                end
            end

            B_SIGN:
            begin
                if (job_reg.has_sign)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_char  = job_reg.sign_char;
                        state_next = B_PREFIX;
                    end
                end
                else
                begin
                    state_next = B_PREFIX;
                end
            end

            B_PREFIX:
            begin
                if (pfx_reg != 2'd0)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        pfx_next  = pfx_reg - 2'd1;
                        if (pfx_reg == 2'd1 && job_reg.prefix_len == 2'd2)
                            emit_char = job_reg.lower ? CHAR_LO_X : CHAR_UP_X;
                        else
                            emit_char = CHAR_ZERO;
                    end
                end
                else
                begin
                    state_next = B_FILL;
                end
            end

            B_FILL:
            begin
                if (job_reg.pad_mode == PAD_FILL && pad_reg != '0)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_char = CHAR_ZERO;
                        pad_next  = pad_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = B_PREC;
                end
            end

            B_PREC:
            begin
                if (precz_reg != '0)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_char  = CHAR_ZERO;
                        precz_next = precz_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = B_DIGITS;
                end
            end

            B_DIGITS:
            begin
                if (dleft_reg != '0)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_char  = digit_char(ram_rdata, job_reg.lower);
                        dleft_next = dleft_reg - DCNT_W'(1);
                        if (dleft_reg > DCNT_W'(1))
                        begin
                            ram_re      = 1'b1;
                            ram_raddr   = rd_idx_reg - DADDR_W'(1);
                            rd_idx_next = ram_raddr;
                        end
                    end
                end
                else
                begin
                    state_next = B_TRAIL;
                end
            end

            B_TRAIL:
            begin
                if (job_reg.pad_mode == PAD_TRAIL && pad_reg != '0)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_char = CHAR_SPACE;
                        pad_next  = pad_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end

            B_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.out_char  = CHAR_NONE;
                    out_item_next.last_char = 1'b1;
                    out_item_next.bad_radix = 1'b1;
                    state_next              = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_item_next.out_char  = emit_char;
            out_item_next.last_char = (remain_reg == CNT_W'(1));
            out_item_next.bad_radix = 1'b0;
            remain_next             = remain_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            dcount_reg    <= '0;
            pad_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dcount_reg    <= dcount_next;
            pad_reg       <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        dv_reg       <= dv_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        dleft_reg    <= dleft_next;
        rd_idx_reg   <= rd_idx_next;
        precz_reg    <= precz_next;
        remain_reg   <= remain_next;
        pfx_reg      <= pfx_next;
        out_item_reg <= out_item_next;
    end

endmodule

// ===== rtl/integer_radix_formatter_top.sv =====
// top level of the printf-style integer to radix string formatter
//
// input channel: in_valid / in_ready / in_item, one number with its base,
// minimum width, precision and flags per transaction
// output channel: out_valid / out_ready / out_item, one ascii character per
// transaction, last_char on the final one; a base outside 2 to 36 gives a
// single transaction with bad_radix set and no characters
//
// the front end classifies a number as it is accepted and drops the job into
// a two-entry queue, so two more numbers are taken while the back end is busy
// back end per number: pickup from the queue, then long division by the base,
// eight quotient bits per cycle, one digit at a time into a 36-entry store, then
// the plan step, then the 7 output phases with one character per transaction;
// the back end finishes one number before it picks up the next
// reset clears the queue, the sequencer and the output valid flag; the digit
// store needs no clearing since every digit is written before it is read
// a stalled receiver holds the output register, the queue fills, in_ready drops
module integer_radix_formatter_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  irf_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output irf_pkg::out_item_t out_item
);
    import irf_pkg::*;

    // front to queue
    logic q_push;
    logic q_full;
    job_t q_push_job;

    // queue to back
    logic q_pop;
    logic q_empty;
    job_t q_head;

    irf_front u_front (
        .in_item  (in_item),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_push_job)
    );

    irf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (q_head)
    );

    irf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== tb/tb_integer_radix_formatter_top.sv =====
// self-checking testbench of the integer radix formatter: directed table, then random numbers
module tb_integer_radix_formatter_top;

    timeunit 1ns;
    timeprecision 1ps;

    import irf_pkg::*;

    // flag bits, in the order they sit at the bottom of in_item_t
    localparam logic [6:0] FLAG_NONE   = 7'b000_0000;
    localparam logic [6:0] FLAG_LEFT   = 7'b100_0000;
    localparam logic [6:0] FLAG_ZERO   = 7'b010_0000;
    localparam logic [6:0] FLAG_PLUS   = 7'b001_0000;
    localparam logic [6:0] FLAG_SPACE  = 7'b000_1000;
    localparam logic [6:0] FLAG_ALT    = 7'b000_0100;
    localparam logic [6:0] FLAG_LOWER  = 7'b000_0010;
    localparam logic [6:0] FLAG_SIGNED = 7'b000_0001;
    localparam logic [6:0] FLAG_ALL    = 7'b111_1111;

    localparam int    CHAR_CAP      = 64;   // characters per number at most
    localparam int    RANDOM_ITEMS  = 305;
    localparam int    MAX_GAP       = 4;
    localparam int    HOLD_CYCLES   = 400;  // long receiver hold-off
    localparam int    HOLD_AT_FIRST = 150;  // characters taken before the first hold-off
    localparam int    HOLD_AT_NEXT  = 900;
    localparam int    DRAIN_CYCLES  = 200;
    localparam string UPPER_DIGITS  = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string LOWER_DIGITS  = "0123456789abcdefghijklmnopqrstuvwxyz";

    // one directed row: a typed-in error, a typed-in string, or left to the predictor
    typedef struct
    {
        in_item_t stim;
        string    text;
        bit       bad;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    out_item_t expected_chars[$];   // characters still owed by the block, oldest first
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;

    integer_radix_formatter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic in_item_t make_item(input logic [VALUE_BITS-1:0] value, input int radix,
                                           input int width, input int prec,
                                           input logic [6:0] flags);
        make_item = {value, RADIX_W'(radix), FIELD_W'(width), PREC_W'(prec), flags};
    endfunction

    task automatic add_row(input in_item_t stim, input string text, input bit bad);
        stim_row_t row;
        row.stim = stim;
        row.text = text;
        row.bad  = bad;
        directed_rows.push_back(row);
    endtask

    // turn a character string into expected transactions, last one marked, capped
    function automatic void queue_chars(input byte unsigned txt[$]);
        int n;
        n = (txt.size() > CHAR_CAP) ? CHAR_CAP : txt.size();
        for (int i = 0; i < n; i++)
            expected_chars.push_back({txt[i], logic'(i == n - 1), 1'b0});
    endfunction

    // printf-style conversion of one number into the characters it should produce
    function automatic void format_number(input in_item_t it);
        byte unsigned          txt[$];
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] base_v;
        logic [DIGIT_W-1:0]    digs [DIGIT_STORE_DEPTH];
        logic [CHAR_W-1:0]     sign_ch;
        string                 digit_set;
        int                    base;
        int                    wid;
        int                    prec;
        int                    ndig;
        int                    room;
        int                    pad;
        bit                    zp;

        base = int'(it.radix);
        if (base < RADIX_MIN || base > RADIX_MAX)
        begin
            expected_chars.push_back({CHAR_NONE, 1'b1, 1'b1});
            return;
        end

        mag       = it.value;
        base_v    = VALUE_BITS'(base);
        digit_set = it.lower_case ? LOWER_DIGITS : UPPER_DIGITS;
        zp        = it.zero_pad && !it.left_align;

        // sign: a negative signed value prints its magnitude, most negative wraps exactly
        if (it.is_signed && mag[VALUE_BITS-1])
        begin
            sign_ch = CHAR_MINUS;
            mag     = '0 - mag;
        end
        else if (it.show_plus)
            sign_ch = CHAR_PLUS;
        else if (it.space_sign)
            sign_ch = CHAR_SPACE;
        else
            sign_ch = CHAR_NONE;

        // oversized width and precision saturate
        wid  = (int'(it.min_width) > MAX_FIELD) ? MAX_FIELD : int'(it.min_width);
        prec = (int'(it.min_digits) > PREC_MAX) ? PREC_MAX : int'(it.min_digits);

        room = wid;
        if (sign_ch != CHAR_NONE)
            room--;
        if (it.alt_prefix && base == 16)
            room -= 2;
        else if (it.alt_prefix && base == 8)
            room--;

        // digits least significant first; zero still gives one digit
        ndig = 0;
        if (mag == '0)
        begin
            digs[0] = '0;
            ndig    = 1;
        end
        else
        begin
            while (mag != '0 && ndig < DIGIT_STORE_DEPTH)
            begin
                digs[ndig] = DIGIT_W'(mag % base_v);
                mag        = mag / base_v;
                ndig++;
            end
        end

        if (ndig > prec)
            prec = ndig;
        room -= prec;
        pad = (room > 0) ? room : 0;

        if (!zp && !it.left_align)
        begin
            repeat (pad) txt.push_back(CHAR_SPACE);
            pad = 0;
        end
        if (sign_ch != CHAR_NONE)
            txt.push_back(sign_ch);
        if (it.alt_prefix && base == 8)
            txt.push_back(CHAR_ZERO);
        if (it.alt_prefix && base == 16)
        begin
            txt.push_back(CHAR_ZERO);
            txt.push_back(digit_set[33]);
        end
        if (zp)
        begin
            repeat (pad) txt.push_back(CHAR_ZERO);
            pad = 0;
        end
        for (int k = ndig; k < prec; k++)
            txt.push_back(CHAR_ZERO);
        for (int k = ndig; k > 0; k--)
            txt.push_back(digit_set[int'(digs[k-1])]);
        repeat (pad) txt.push_back(CHAR_SPACE);

        queue_chars(txt);
    endfunction

    // expectations of one directed row
    function automatic void expect_row(input stim_row_t row);
        byte unsigned txt[$];
        if (row.bad)
            expected_chars.push_back({CHAR_NONE, 1'b1, 1'b1});
        else if (row.text.len() > 0)
        begin
            for (int i = 0; i < row.text.len(); i++)
                txt.push_back(row.text[i]);
            queue_chars(txt);
        end
        else
            format_number(row.stim);
    endfunction

    // random number: mostly valid bases and modest sizes, now and then extremes
    function automatic in_item_t random_item();
        in_item_t it;
        it = '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.value = $urandom;
            4, 5, 6:    it.value = VALUE_BITS'($urandom_range(0, 200));
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       it.value = '0;
                    1:       it.value = '1;
                    2:       it.value = 32'h8000_0000;
                    default: it.value = 32'h7FFF_FFFF;
                endcase
            end
            default:    it.value = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 19))
            0, 1:       it.radix = RADIX_W'($urandom_range(0, 63));
            2, 3:       it.radix = RADIX_W'(16);
            4, 5:       it.radix = RADIX_W'(10);
            6:          it.radix = RADIX_W'(8);
            7:          it.radix = RADIX_W'(2);
            default:    it.radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        endcase
        it.min_width  = ($urandom_range(0, 5) == 0) ? FIELD_W'($urandom_range(0, 127))
                                                    : FIELD_W'($urandom_range(0, 16));
        it.min_digits = ($urandom_range(0, 5) == 0) ? PREC_W'($urandom_range(0, 63))
                                                    : PREC_W'($urandom_range(0, 10));
        {it.left_align, it.zero_pad, it.show_plus, it.space_sign,
         it.alt_prefix, it.lower_case, it.is_signed} = 7'($urandom_range(0, 127));
        return it;
    endfunction

    // offer one number; returns in the active region of the edge that took it
    task automatic offer_item(input in_item_t it, input bit no_idle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic void note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        $error("%s: expected %0h, actual %0h", field, want, got);
    endfunction

    // sender: directed table first, then random numbers
    initial
    begin : sender
        in_item_t item_now;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;

        // invalid bases, each a single error transaction
        add_row(make_item(32'd42, 0, 0, 0, FLAG_NONE), "", 1'b1);
        add_row(make_item(32'd42, 1, 0, 0, FLAG_NONE), "", 1'b1);
        add_row(make_item(32'd42, 37, 0, 0, FLAG_NONE), "", 1'b1);
        add_row(make_item(32'hFFFF_FFFF, 63, 127, 63, FLAG_ALL), "", 1'b1);
        // zero value still prints one digit
        add_row(make_item(32'd0, 10, 0, 0, FLAG_NONE), "0", 1'b0);
        // value extremes in the smallest and largest bases, and in decimal
        add_row(make_item(32'hFFFF_FFFF, 2, 0, 0, FLAG_NONE),
                "11111111111111111111111111111111", 1'b0);
        add_row(make_item(32'hFFFF_FFFF, 36, 0, 0, FLAG_NONE), "1Z141Z3", 1'b0);
        add_row(make_item(32'hFFFF_FFFF, 36, 0, 0, FLAG_LOWER), "1z141z3", 1'b0);
        add_row(make_item(32'hFFFF_FFFF, 10, 0, 0, FLAG_NONE), "4294967295", 1'b0);
        // signed extremes: the most negative value keeps its full magnitude
        add_row(make_item(32'h8000_0000, 10, 0, 0, FLAG_SIGNED), "-2147483648", 1'b0);
        add_row(make_item(32'h7FFF_FFFF, 10, 0, 0, FLAG_SIGNED | FLAG_PLUS),
                "+2147483647", 1'b0);
        // prefixes and sign characters
        add_row(make_item(32'd255, 16, 0, 0, FLAG_ALT | FLAG_LOWER), "0xff", 1'b0);
        add_row(make_item(32'd255, 16, 0, 0, FLAG_ALT), "0XFF", 1'b0);
        add_row(make_item(32'd8, 8, 0, 0, FLAG_ALT), "010", 1'b0);
        add_row(make_item(32'd42, 10, 0, 0, FLAG_SPACE), " 42", 1'b0);
        // padding: right aligned, left aligned, zero fill, zero fill under left align, precision, signed zero fill
        add_row(make_item(32'd42, 10, 5, 0, FLAG_NONE), "   42", 1'b0);
        add_row(make_item(32'd42, 10, 5, 0, FLAG_LEFT), "42   ", 1'b0);
        add_row(make_item(32'd42, 10, 5, 0, FLAG_ZERO), "00042", 1'b0);
        add_row(make_item(32'd42, 10, 5, 0, FLAG_ZERO | FLAG_LEFT), "42   ", 1'b0);
        add_row(make_item(32'd5, 10, 0, 3, FLAG_NONE), "005", 1'b0);
        add_row(make_item(32'hFFFF_FFFB, 10, 6, 0, FLAG_ZERO | FLAG_SIGNED), "-00005", 1'b0);
        // saturating width and precision and other flag mixes, left to the predictor
        add_row(make_item(32'd12345, 10, 127, 0, FLAG_PLUS), "", 1'b0);
        add_row(make_item(32'd1, 2, 0, 63, FLAG_NONE), "", 1'b0);
        add_row(make_item(32'hFFFF_FFFF, 16, 64, 20,
                          FLAG_ALT | FLAG_LOWER | FLAG_SIGNED | FLAG_PLUS | FLAG_ZERO),
                "", 1'b0);
        add_row(make_item(32'd0, 16, 10, 0, FLAG_ALT | FLAG_LEFT | FLAG_SPACE), "", 1'b0);
        add_row(make_item(32'hDEAD_BEEF, 36, 40, 33, FLAG_ALL), "", 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i].stim, 1'b0);
            expect_row(directed_rows[i]);
        end

        // random part, with back-to-back stretches now and then
        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            item_now = random_item();
            offer_item(item_now, (idx % 60) >= 45);
            format_number(item_now);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // let every owed character arrive, then watch a while for strays
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stalls, stall-free stretches, and two long hold-offs
    // during which the sender keeps offering so the job queue fills and in_ready drops
    initial
    begin : receiver
        int gap;
        int taken;

        out_ready = 1'b0;
        taken     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (taken == HOLD_AT_FIRST || taken == HOLD_AT_NEXT)
                gap = HOLD_CYCLES;
            else if (((taken / 40) % 4) == 3)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // every output transaction against the oldest owed character
    always @(posedge clk)
    begin : char_checker
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
                note_mismatch("out_item (none expected)", 0, int'(out_item));
            else
            begin
                want = expected_chars.pop_front();
                if (out_item.out_char !== want.out_char)
                    note_mismatch("out_char", int'(want.out_char), int'(out_item.out_char));
                if (out_item.last_char !== want.last_char)
                    note_mismatch("last_char", int'(want.last_char), int'(out_item.last_char));
                if (out_item.bad_radix !== want.bad_radix)
                    note_mismatch("bad_radix", int'(want.bad_radix), int'(out_item.bad_radix));
            end
        end
    end

    // hang guard, several times the slowest legal run
    initial
    begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/irf_pkg.sv
rtl/irf_ram.sv
rtl/irf_front.sv
rtl/irf_queue.sv
rtl/irf_back.sv
rtl/integer_radix_formatter_top.sv
tb/tb_integer_radix_formatter_top.sv
